// File: design/es2cal_pkg.sv
package es2cal_pkg;

   // default width of the seconds count
   localparam int SECONDS_WIDTH_DEFAULT = 36;

   // result field widths
   localparam int SEC_WIDTH  = 6;
   localparam int MIN_WIDTH  = 6;
   localparam int HOUR_WIDTH = 5;
   localparam int WDAY_WIDTH = 3;
   localparam int YEAR_WIDTH = 12;
   localparam int YDAY_WIDTH = 9;
   localparam int MON_WIDTH  = 4;
   localparam int MDAY_WIDTH = 5;

   // day split
   localparam int SECONDS_PER_DAY   = 86400;
   localparam int SOD_WIDTH         = $clog2(SECONDS_PER_DAY);
   localparam int EPOCH_SHIFT       = 719468;
   localparam int EPOCH_SHIFT_WIDTH = $clog2(EPOCH_SHIFT + 1);
   localparam int DAYS_PER_WEEK     = 7;
   localparam int WEEKDAY_OFFSET    = 4;

   // constant dividers take one digit of this many bits per two stages
   localparam int DIV_CHUNK = 8;

   // time of day, reciprocal multiplies
   localparam int REST_WIDTH                  = 12;
   localparam int HOUR_RECIP_WIDTH            = 16;
   localparam logic [HOUR_RECIP_WIDTH-1:0] HOUR_RECIP = 16'd37283;
   localparam int HOUR_SHIFT                  = 27;
   localparam logic [SOD_WIDTH-1:0] SECS_PER_HOUR = 17'd3600;
   localparam int MIN_RECIP_WIDTH             = 12;
   localparam logic [MIN_RECIP_WIDTH-1:0] MIN_RECIP = 12'd2185;
   localparam int MIN_SHIFT                   = 17;
   localparam logic [REST_WIDTH-1:0] SECS_PER_MIN = 12'd60;

   // 400-year cycle
   localparam int DAYS_400Y  = 146097;
   localparam int DOE_WIDTH  = $clog2(DAYS_400Y);
   localparam logic [DOE_WIDTH-1:0] DAYS_100Y     = 18'd36524;
   localparam logic [DOE_WIDTH-1:0] DAYS_400Y_M1  = 18'd146096;
   localparam int RECIP_WIDTH = 18;
   localparam logic [RECIP_WIDTH-1:0] QUAD_RECIP = 18'd183860;
   localparam int QUAD_SHIFT  = 28;
   localparam int QUAD_WIDTH  = 7;
   localparam logic [RECIP_WIDTH-1:0] YOE_RECIP  = 18'd183860;
   localparam int YOE_SHIFT   = 26;
   localparam int YOE_WIDTH   = 9;
   localparam logic [DOE_WIDTH-1:0] DAYS_1Y = 18'd365;
   localparam logic [YEAR_WIDTH-1:0] YEARS_400  = 12'd400;
   localparam logic [YEAR_WIDTH-1:0] YEAR_BASE  = 12'd1900;

   // month selection
   localparam int MP_WIDTH = 4;
   localparam logic [MP_WIDTH-1:0] MP_JANUARY = 4'd10;
   localparam logic [MON_WIDTH-1:0] MON_MARCH = 4'd2;
   localparam logic [YDAY_WIDTH-1:0] MARCH_START [12] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
      9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
   };
   localparam logic [YDAY_WIDTH-1:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // register stages of the date unit
   localparam int CIVIL_STAGES = 7;

   typedef struct packed {
      logic [SEC_WIDTH-1:0]  second;
      logic [MIN_WIDTH-1:0]  minute;
      logic [HOUR_WIDTH-1:0] hour;
      logic [WDAY_WIDTH-1:0] weekday;
   } tod_type;

   typedef struct packed {
      logic [YEAR_WIDTH-1:0] years_since_1900;
      logic [YDAY_WIDTH-1:0] day_of_year;
      logic [MON_WIDTH-1:0]  month;
      logic [MDAY_WIDTH-1:0] day_of_month;
   } date_type;

endpackage

// File: design/es2cal_if.sv
interface es2cal_req_if #(
   parameter int SECONDS_WIDTH = es2cal_pkg::SECONDS_WIDTH_DEFAULT
);
   logic                     valid;
   logic                     ready;
   logic [SECONDS_WIDTH-1:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface es2cal_rsp_if;
   import es2cal_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SEC_WIDTH-1:0]  second;
   logic [MIN_WIDTH-1:0]  minute;
   logic [HOUR_WIDTH-1:0] hour;
   logic [WDAY_WIDTH-1:0] weekday;
   logic [YEAR_WIDTH-1:0] years_since_1900;
   logic [YDAY_WIDTH-1:0] day_of_year;
   logic [MON_WIDTH-1:0]  month;
   logic [MDAY_WIDTH-1:0] day_of_month;

   modport source (
      output valid, output second, output minute, output hour, output weekday,
      output years_since_1900, output day_of_year, output month, output day_of_month,
      input ready
   );
   modport sink (
      input valid, input second, input minute, input hour, input weekday,
      input years_since_1900, input day_of_year, input month, input day_of_month,
      output ready
   );
endinterface

// File: design/es2cal_cdiv.sv
module es2cal_cdiv #(
   parameter int WIDTH   = 36,
   parameter int DIVISOR = 86400
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [WIDTH-1:0]             dividend,
   output logic                         out_valid,
   output logic [WIDTH-1:0]             quotient,
   output logic [$clog2(DIVISOR)-1:0]   remainder
);
   import es2cal_pkg::*;

   localparam int REM_WIDTH   = $clog2(DIVISOR);
   localparam int STEPS       = (WIDTH + DIV_CHUNK - 1) / DIV_CHUNK;
   localparam int STAGES      = 2 * STEPS;
   localparam int PAD_WIDTH   = STEPS * DIV_CHUNK;
   localparam int PART_WIDTH  = REM_WIDTH + DIV_CHUNK;
   localparam int RECIP_SHIFT = PART_WIDTH + REM_WIDTH;
   localparam int RECIP_BITS  = PART_WIDTH + 1;
   localparam int PROD_WIDTH  = PART_WIDTH + RECIP_BITS;
   localparam longint RECIP_VALUE = ((longint'(1) << RECIP_SHIFT) + longint'(DIVISOR) - 1)
                                    / longint'(DIVISOR);
   localparam logic [RECIP_BITS-1:0] RECIP     = RECIP_BITS'(RECIP_VALUE);
   localparam logic [PART_WIDTH-1:0] DIVISOR_P = PART_WIDTH'(DIVISOR);

   logic [STAGES-1:0]     vld_ff;
   logic [PAD_WIDTH-1:0]  word_a_ff [STEPS];
   logic [PART_WIDTH-1:0] part_ff   [STEPS];
   logic [DIV_CHUNK-1:0]  quot_ff   [STEPS];
   logic [PAD_WIDTH-1:0]  word_b_ff [STEPS];
   logic [REM_WIDTH-1:0]  rem_ff    [STEPS];

   // valid bits follow the words down the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // one quotient digit per two stages, dividend shifts out as quotient shifts in
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [PAD_WIDTH-1:0]  word_src;
      logic [REM_WIDTH-1:0]  rem_src;
      logic [PART_WIDTH-1:0] part_in;
      logic [PROD_WIDTH-1:0] prod;
      logic [DIV_CHUNK-1:0]  quot_in;
      logic [PART_WIDTH-1:0] rem_full;

      if (i == 0) begin : g_head
         assign word_src = PAD_WIDTH'(dividend);
         assign rem_src  = '0;
      end else begin : g_body
         assign word_src = word_b_ff[i-1];
         assign rem_src  = rem_ff[i-1];
      end

      // first stage: quotient digit by reciprocal multiply
      assign part_in = {rem_src, word_src[PAD_WIDTH-1 -: DIV_CHUNK]};
      assign prod    = PROD_WIDTH'(part_in) * PROD_WIDTH'(RECIP);
      assign quot_in = prod[RECIP_SHIFT +: DIV_CHUNK];

      always_ff @(posedge clock) begin
         if (en) begin
            word_a_ff[i] <= PAD_WIDTH'({word_src, quot_in});
            part_ff[i]   <= part_in;
            quot_ff[i]   <= quot_in;
         end
      end

      // second stage: remainder carried into the next digit
      assign rem_full = part_ff[i] - PART_WIDTH'(quot_ff[i]) * DIVISOR_P;

      always_ff @(posedge clock) begin
         if (en) begin
            word_b_ff[i] <= word_a_ff[i];
            rem_ff[i]    <= REM_WIDTH'(rem_full);
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign quotient  = word_b_ff[STEPS-1][WIDTH-1:0];
   assign remainder = rem_ff[STEPS-1];

endmodule

// File: design/es2cal_dly.sv
module es2cal_dly #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 28
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   // side words ride alongside the divider chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_tap
      logic [WIDTH-1:0] tap_in;

      if (i == 0) begin : g_head
         assign tap_in = data_in;
      end else begin : g_body
         assign tap_in = tap_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tap_ff[i] <= tap_in;
         end
      end
   end

   assign data_out = tap_ff[DEPTH-1];

endmodule

// File: design/es2cal_tod.sv
module es2cal_tod #(
   parameter int DAYS_WIDTH = 20,
   parameter int Z_WIDTH    = 21
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [DAYS_WIDTH-1:0]          days,
   input  logic [es2cal_pkg::SOD_WIDTH-1:0] sod,
   output logic                           out_valid,
   output logic [Z_WIDTH-1:0]             z,
   output es2cal_pkg::tod_type            tod
);
   import es2cal_pkg::*;

   localparam int DIGITS      = (DAYS_WIDTH + 2) / 3;
   localparam int WSUM_WIDTH  = $clog2(7 * DIGITS + 1);
   localparam int FOLD_WIDTH  = 5;
   localparam int STAGES      = 4;

   logic [STAGES-1:0] vld_ff;

   // stage 1: hour by reciprocal, octal digit sum of the day count, shifted day count
   logic [SOD_WIDTH+HOUR_RECIP_WIDTH-1:0] hour_prod;
   logic [3*DIGITS-1:0]                   days_pad;
   logic [WSUM_WIDTH-1:0]                 wsum_in;
   logic [HOUR_WIDTH-1:0]                 hour1_in;
   logic [Z_WIDTH-1:0]                    z1_in;
   logic [SOD_WIDTH-1:0]                  sod1_ff;
   logic [HOUR_WIDTH-1:0]                 hour1_ff;
   logic [WSUM_WIDTH-1:0]                 wsum1_ff;
   logic [Z_WIDTH-1:0]                    z1_ff;

   assign hour_prod = (SOD_WIDTH + HOUR_RECIP_WIDTH)'(sod)
                      * (SOD_WIDTH + HOUR_RECIP_WIDTH)'(HOUR_RECIP);
   assign hour1_in  = hour_prod[HOUR_SHIFT +: HOUR_WIDTH];
   assign days_pad  = (3 * DIGITS)'(days);
   assign z1_in     = Z_WIDTH'(days) + Z_WIDTH'(EPOCH_SHIFT);

   // eight is one modulo seven, so the digits sum keeps the residue
   always_comb begin
      wsum_in = '0;
      for (int k = 0; k < DIGITS; k++) begin
         wsum_in = wsum_in + WSUM_WIDTH'(days_pad[3*k +: 3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sod1_ff  <= sod;
         hour1_ff <= hour1_in;
         wsum1_ff <= wsum_in;
         z1_ff    <= z1_in;
      end
   end

   // stage 2: seconds left in the hour, first residue fold with the epoch weekday
   logic [SOD_WIDTH-1:0]  hour_secs;
   logic [REST_WIDTH-1:0] rest2_in;
   logic [FOLD_WIDTH-1:0] fold2_in;
   logic [HOUR_WIDTH-1:0] hour2_ff;
   logic [REST_WIDTH-1:0] rest2_ff;
   logic [FOLD_WIDTH-1:0] fold2_ff;
   logic [Z_WIDTH-1:0]    z2_ff;

   assign hour_secs = SOD_WIDTH'(hour1_ff) * SECS_PER_HOUR;
   assign rest2_in  = REST_WIDTH'(sod1_ff - hour_secs);
   assign fold2_in  = FOLD_WIDTH'(wsum1_ff >> 3) + FOLD_WIDTH'(wsum1_ff[2:0])
                      + FOLD_WIDTH'(WEEKDAY_OFFSET);

   always_ff @(posedge clock) begin
      if (en) begin
         hour2_ff <= hour1_ff;
         rest2_ff <= rest2_in;
         fold2_ff <= fold2_in;
         z2_ff    <= z1_ff;
      end
   end

   // stage 3: minute by reciprocal, weekday from the second fold
   logic [REST_WIDTH+MIN_RECIP_WIDTH-1:0] min_prod;
   logic [MIN_WIDTH-1:0]  min3_in;
   logic [3:0]            fold3;
   logic [WDAY_WIDTH-1:0] wday3_in;
   logic [HOUR_WIDTH-1:0] hour3_ff;
   logic [REST_WIDTH-1:0] rest3_ff;
   logic [MIN_WIDTH-1:0]  min3_ff;
   logic [WDAY_WIDTH-1:0] wday3_ff;
   logic [Z_WIDTH-1:0]    z3_ff;

   assign min_prod = (REST_WIDTH + MIN_RECIP_WIDTH)'(rest2_ff)
                     * (REST_WIDTH + MIN_RECIP_WIDTH)'(MIN_RECIP);
   assign min3_in  = min_prod[MIN_SHIFT +: MIN_WIDTH];
   assign fold3    = 4'(fold2_ff[4:3]) + 4'(fold2_ff[2:0]);
   assign wday3_in = (fold3 >= 4'(DAYS_PER_WEEK)) ? WDAY_WIDTH'(fold3 - 4'(DAYS_PER_WEEK))
                                                  : WDAY_WIDTH'(fold3);

   always_ff @(posedge clock) begin
      if (en) begin
         hour3_ff <= hour2_ff;
         rest3_ff <= rest2_ff;
         min3_ff  <= min3_in;
         wday3_ff <= wday3_in;
         z3_ff    <= z2_ff;
      end
   end

   // stage 4: second of the minute
   logic [SEC_WIDTH-1:0] sec4_in;
   tod_type              tod4_ff;
   logic [Z_WIDTH-1:0]   z4_ff;

   assign sec4_in = SEC_WIDTH'(rest3_ff - REST_WIDTH'(min3_ff) * SECS_PER_MIN);

   always_ff @(posedge clock) begin
      if (en) begin
         tod4_ff.second  <= sec4_in;
         tod4_ff.minute  <= min3_ff;
         tod4_ff.hour    <= hour3_ff;
         tod4_ff.weekday <= wday3_ff;
         z4_ff           <= z3_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign z         = z4_ff;
   assign tod       = tod4_ff;

endmodule

// File: design/es2cal_civil.sv
module es2cal_civil #(
   parameter int ERA_WIDTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [es2cal_pkg::DOE_WIDTH-1:0] doe,
   input  logic [ERA_WIDTH-1:0]             era,
   output logic                             out_valid,
   output es2cal_pkg::date_type             date
);
   import es2cal_pkg::*;

   logic [CIVIL_STAGES-1:0] vld_ff;

   // stage 1: corrections for 4-, 100- and 400-year boundaries, era years
   logic [DOE_WIDTH+RECIP_WIDTH-1:0] quad_prod;
   logic [QUAD_WIDTH-1:0] quad1_in;
   logic [2:0]            cent1_in;
   logic                  last1_in;
   logic [YEAR_WIDTH-1:0] eyear1_in;
   logic [DOE_WIDTH-1:0]  doe1_ff;
   logic [QUAD_WIDTH-1:0] quad1_ff;
   logic [2:0]            cent1_ff;
   logic                  last1_ff;
   logic [YEAR_WIDTH-1:0] eyear1_ff;

   assign quad_prod = (DOE_WIDTH + RECIP_WIDTH)'(doe) * (DOE_WIDTH + RECIP_WIDTH)'(QUAD_RECIP);
   assign quad1_in  = quad_prod[QUAD_SHIFT +: QUAD_WIDTH];
   assign cent1_in  = 3'(doe >= DAYS_100Y) + 3'(doe >= 2 * DAYS_100Y)
                      + 3'(doe >= 3 * DAYS_100Y) + 3'(doe >= DAYS_400Y_M1);
   assign last1_in  = doe == DAYS_400Y_M1;
   assign eyear1_in = YEAR_WIDTH'(era) * YEARS_400;

   always_ff @(posedge clock) begin
      if (en) begin
         doe1_ff   <= doe;
         quad1_ff  <= quad1_in;
         cent1_ff  <= cent1_in;
         last1_ff  <= last1_in;
         eyear1_ff <= eyear1_in;
      end
   end

   // stage 2: day count on a uniform 365-day grid
   logic [DOE_WIDTH-1:0]  flat2_in;
   logic [DOE_WIDTH-1:0]  doe2_ff;
   logic [DOE_WIDTH-1:0]  flat2_ff;
   logic [YEAR_WIDTH-1:0] eyear2_ff;

   assign flat2_in = doe1_ff - DOE_WIDTH'(quad1_ff) + DOE_WIDTH'(cent1_ff)
                     - DOE_WIDTH'(last1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         doe2_ff   <= doe1_ff;
         flat2_ff  <= flat2_in;
         eyear2_ff <= eyear1_ff;
      end
   end

   // stage 3: year of era by reciprocal of 365
   logic [DOE_WIDTH+RECIP_WIDTH-1:0] yoe_prod;
   logic [YOE_WIDTH-1:0]  yoe3_in;
   logic [DOE_WIDTH-1:0]  doe3_ff;
   logic [YOE_WIDTH-1:0]  yoe3_ff;
   logic [YEAR_WIDTH-1:0] eyear3_ff;

   assign yoe_prod = (DOE_WIDTH + RECIP_WIDTH)'(flat2_ff) * (DOE_WIDTH + RECIP_WIDTH)'(YOE_RECIP);
   assign yoe3_in  = yoe_prod[YOE_SHIFT +: YOE_WIDTH];

   always_ff @(posedge clock) begin
      if (en) begin
         doe3_ff   <= doe2_ff;
         yoe3_ff   <= yoe3_in;
         eyear3_ff <= eyear2_ff;
      end
   end

   // stage 4: day within the march-based year
   logic [1:0]            cent4;
   logic [DOE_WIDTH-1:0]  year_days;
   logic [YDAY_WIDTH-1:0] doy4_in;
   logic [YDAY_WIDTH-1:0] doy4_ff;
   logic [YOE_WIDTH-1:0]  yoe4_ff;
   logic [YEAR_WIDTH-1:0] eyear4_ff;

   assign cent4     = 2'(yoe3_ff >= 9'd100) + 2'(yoe3_ff >= 9'd200) + 2'(yoe3_ff >= 9'd300);
   assign year_days = DOE_WIDTH'(yoe3_ff) * DAYS_1Y + DOE_WIDTH'(yoe3_ff[YOE_WIDTH-1:2])
                      - DOE_WIDTH'(cent4);
   assign doy4_in   = YDAY_WIDTH'(doe3_ff - year_days);

   always_ff @(posedge clock) begin
      if (en) begin
         doy4_ff   <= doy4_in;
         yoe4_ff   <= yoe3_ff;
         eyear4_ff <= eyear3_ff;
      end
   end

   // stage 5: month from march by boundary compares
   logic [MP_WIDTH-1:0]   mp5_in;
   logic [MP_WIDTH-1:0]   mp5_ff;
   logic [YDAY_WIDTH-1:0] doy5_ff;
   logic [YOE_WIDTH-1:0]  yoe5_ff;
   logic [YEAR_WIDTH-1:0] eyear5_ff;

   always_comb begin
      mp5_in = '0;
      for (int k = 1; k < 12; k++) begin
         mp5_in = mp5_in + MP_WIDTH'(doy4_ff >= MARCH_START[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mp5_ff    <= mp5_in;
         doy5_ff   <= doy4_ff;
         yoe5_ff   <= yoe4_ff;
         eyear5_ff <= eyear4_ff;
      end
   end

   // stage 6: day of month, january-based month, calendar year
   logic                  jan_feb;
   logic [MDAY_WIDTH-1:0] mday6_in;
   logic [MON_WIDTH-1:0]  mon6_in;
   logic [YOE_WIDTH-1:0]  cyc6_in;
   logic [YEAR_WIDTH-1:0] year6_in;
   logic [MDAY_WIDTH-1:0] mday6_ff;
   logic [MON_WIDTH-1:0]  mon6_ff;
   logic [YOE_WIDTH-1:0]  cyc6_ff;
   logic [YEAR_WIDTH-1:0] year6_ff;

   assign jan_feb  = mp5_ff >= MP_JANUARY;
   assign mday6_in = MDAY_WIDTH'(doy5_ff - MARCH_START[mp5_ff] + YDAY_WIDTH'(1));
   assign mon6_in  = jan_feb ? MON_WIDTH'(mp5_ff - MP_JANUARY) : MON_WIDTH'(mp5_ff) + MON_MARCH;
   assign cyc6_in  = yoe5_ff + YOE_WIDTH'(jan_feb);
   assign year6_in = eyear5_ff + YEAR_WIDTH'(yoe5_ff) + YEAR_WIDTH'(jan_feb) - YEAR_BASE;

   always_ff @(posedge clock) begin
      if (en) begin
         mday6_ff <= mday6_in;
         mon6_ff  <= mon6_in;
         cyc6_ff  <= cyc6_in;
         year6_ff <= year6_in;
      end
   end

   // stage 7: leap rule on the year within its 400-year cycle, day of year
   logic                  leap;
   logic [YDAY_WIDTH-1:0] yday7_in;
   date_type              date7_ff;

   assign leap     = (cyc6_ff[1:0] == 2'd0)
                     && !(cyc6_ff == 9'd100 || cyc6_ff == 9'd200 || cyc6_ff == 9'd300);
   assign yday7_in = MONTH_START[mon6_ff] + YDAY_WIDTH'(mday6_ff) - YDAY_WIDTH'(1)
                     + YDAY_WIDTH'(leap && (mon6_ff >= MON_MARCH));

   always_ff @(posedge clock) begin
      if (en) begin
         date7_ff.years_since_1900 <= year6_ff;
         date7_ff.day_of_year      <= yday7_in;
         date7_ff.month            <= mon6_ff;
         date7_ff.day_of_month     <= mday6_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[CIVIL_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[CIVIL_STAGES-1];
   assign date      = date7_ff;

endmodule

// File: design/epoch_seconds_to_calendar.sv
// channel    dir  handshake      word
// req_chan   in   valid / ready  epoch_seconds
// rsp_chan   out  valid / ready  second, minute, hour, weekday, years_since_1900,
//                                day_of_year, month, day_of_month
//
// accepts one word per cycle while no result is stalled; the shifted day count
// is 21 bits wide at the default width
// the two constant dividers (by 86400 and by 146097) work one byte at a time
// synchronous reset clears the valid bits only
// a stalled result freezes the whole pipe; req_chan.ready is low only then
module epoch_seconds_to_calendar #(
   parameter int SECONDS_WIDTH = es2cal_pkg::SECONDS_WIDTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   es2cal_req_if.sink   req_chan,
   es2cal_rsp_if.source rsp_chan
);
   import es2cal_pkg::*;

   localparam int DAYS_WIDTH = SECONDS_WIDTH - SOD_WIDTH + 1;
   localparam int Z_WIDTH    = ((DAYS_WIDTH > EPOCH_SHIFT_WIDTH) ? DAYS_WIDTH
                                                                 : EPOCH_SHIFT_WIDTH) + 1;
   localparam int ERA_WIDTH  = Z_WIDTH - DOE_WIDTH + 1;
   localparam int ERA_DIV_STAGES = 2 * ((Z_WIDTH + DIV_CHUNK - 1) / DIV_CHUNK);

   logic en;

   // pipe advances unless a result is held
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // seconds into whole days and second of day
   logic                     day_vld;
   logic [SECONDS_WIDTH-1:0] day_quot;
   logic [SOD_WIDTH-1:0]     sod;

   es2cal_cdiv #(
      .WIDTH   (SECONDS_WIDTH),
      .DIVISOR (SECONDS_PER_DAY)
   ) u_day_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .dividend  (req_chan.epoch_seconds),
      .out_valid (day_vld),
      .quotient  (day_quot),
      .remainder (sod)
   );

   // time of day, weekday, day count from the march-based origin
   logic               tod_vld;
   logic [Z_WIDTH-1:0] z;
   tod_type            tod;

   es2cal_tod #(
      .DAYS_WIDTH (DAYS_WIDTH),
      .Z_WIDTH    (Z_WIDTH)
   ) u_tod (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (day_vld),
      .days      (day_quot[DAYS_WIDTH-1:0]),
      .sod       (sod),
      .out_valid (tod_vld),
      .z         (z),
      .tod       (tod)
   );

   // day count into 400-year eras and day of era
   logic               era_vld;
   logic [Z_WIDTH-1:0] era_quot;
   logic [DOE_WIDTH-1:0] doe;

   es2cal_cdiv #(
      .WIDTH   (Z_WIDTH),
      .DIVISOR (DAYS_400Y)
   ) u_era_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (tod_vld),
      .dividend  (z),
      .out_valid (era_vld),
      .quotient  (era_quot),
      .remainder (doe)
   );

   // time of day waits for the date
   tod_type tod_late;

   es2cal_dly #(
      .WIDTH ($bits(tod_type)),
      .DEPTH (ERA_DIV_STAGES + CIVIL_STAGES)
   ) u_tod_dly (
      .clock    (clock),
      .en       (en),
      .data_in  (tod),
      .data_out (tod_late)
   );

   // calendar date from era and day of era
   logic     date_vld;
   date_type date;

   es2cal_civil #(
      .ERA_WIDTH (ERA_WIDTH)
   ) u_civil (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (era_vld),
      .doe       (doe),
      .era       (era_quot[ERA_WIDTH-1:0]),
      .out_valid (date_vld),
      .date      (date)
   );

   // result word
   assign rsp_chan.valid            = date_vld;
   assign rsp_chan.second           = tod_late.second;
   assign rsp_chan.minute           = tod_late.minute;
   assign rsp_chan.hour             = tod_late.hour;
   assign rsp_chan.weekday          = tod_late.weekday;
   assign rsp_chan.years_since_1900 = date.years_since_1900;
   assign rsp_chan.day_of_year      = date.day_of_year;
   assign rsp_chan.month            = date.month;
   assign rsp_chan.day_of_month     = date.day_of_month;

endmodule

// File: tb/calendar_check.sv
module calendar_check #(
   parameter int SECONDS_WIDTH = es2cal_pkg::SECONDS_WIDTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   es2cal_req_if  seconds_mon,
   es2cal_rsp_if  calendar_mon,
   output int     fail_count,
   output int     outstanding
);
   import es2cal_pkg::*;

   typedef struct packed {
      tod_type  tod;
      date_type date;
   } calendar_type;

   typedef struct {
      logic [SECONDS_WIDTH-1:0] stamp;
      calendar_type             cal;
   } pending_date_type;

   pending_date_type pending_dates[$];
   int               fail_total = 0;
   int               pending_total = 0;

   assign fail_count  = fail_total;
   assign outstanding = pending_total;

   // days from january 1 to the first of a month, common year
   function automatic logic [63:0] days_before(logic [63:0] mon);
      case (mon)
         0: return 0;
         1: return 31;
         2: return 59;
         3: return 90;
         4: return 120;
         5: return 151;
         6: return 181;
         7: return 212;
         8: return 243;
         9: return 273;
         10: return 304;
         default: return 334;
      endcase
   endfunction

   // broken-down utc date and time of a seconds count
   function automatic calendar_type to_calendar(logic [SECONDS_WIDTH-1:0] stamp);
      logic [63:0]  t, days, z, era, doe, yoe, year, doy_mar, mp, mday, mon, yday;
      logic         leap;
      calendar_type cal;
      t = 64'(stamp);
      cal.tod.second = SEC_WIDTH'(t % 60);
      t = t / 60;
      cal.tod.minute = MIN_WIDTH'(t % 60);
      t = t / 60;
      cal.tod.hour = HOUR_WIDTH'(t % 24);
      days = t / 24;
      // the epoch fell on a thursday
      cal.tod.weekday = WDAY_WIDTH'((days + 4) % 7);
      // split days into eras and years that begin on march 1
      z = days + 64'(EPOCH_SHIFT);
      era = z / DAYS_400Y;
      doe = z - era * DAYS_400Y;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      year = yoe + era * 400;
      doy_mar = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy_mar + 2) / 153;
      mday = doy_mar - (153 * mp + 2) / 5 + 1;
      mon = (mp < 10) ? mp + 2 : mp - 10;
      if (mon < 2) begin
         year = year + 1;
      end
      leap = ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
      yday = days_before(mon) + mday - 1 + ((leap && mon > 1) ? 64'd1 : 64'd0);
      cal.date.years_since_1900 = YEAR_WIDTH'(year - 1900);
      cal.date.day_of_year = YDAY_WIDTH'(yday);
      cal.date.month = MON_WIDTH'(mon);
      cal.date.day_of_month = MDAY_WIDTH'(mday);
      return cal;
   endfunction

   task automatic compare_field(string field, logic [SECONDS_WIDTH-1:0] stamp,
                                int expected, int actual);
      if (expected != actual) begin
         $display("%0t: seconds %0d %s expected %0d actual %0d",
                  $time, stamp, field, expected, actual);
         fail_total++;
      end
   endtask

   // retire results against the oldest prediction, then record new words
   always @(posedge clock) begin
      pending_date_type exp_date;
      if (!reset) begin
         if (calendar_mon.valid && calendar_mon.ready) begin
            if (pending_dates.size() == 0) begin
               $display("%0t: result word with nothing expected", $time);
               fail_total++;
            end else begin
               exp_date = pending_dates.pop_front();
               compare_field("second", exp_date.stamp, exp_date.cal.tod.second,
                             calendar_mon.second);
               compare_field("minute", exp_date.stamp, exp_date.cal.tod.minute,
                             calendar_mon.minute);
               compare_field("hour", exp_date.stamp, exp_date.cal.tod.hour,
                             calendar_mon.hour);
               compare_field("weekday", exp_date.stamp, exp_date.cal.tod.weekday,
                             calendar_mon.weekday);
               compare_field("years_since_1900", exp_date.stamp,
                             exp_date.cal.date.years_since_1900,
                             calendar_mon.years_since_1900);
               compare_field("day_of_year", exp_date.stamp, exp_date.cal.date.day_of_year,
                             calendar_mon.day_of_year);
               compare_field("month", exp_date.stamp, exp_date.cal.date.month,
                             calendar_mon.month);
               compare_field("day_of_month", exp_date.stamp,
                             exp_date.cal.date.day_of_month, calendar_mon.day_of_month);
            end
         end
         if (seconds_mon.valid && seconds_mon.ready) begin
            exp_date.stamp = seconds_mon.epoch_seconds;
            exp_date.cal = to_calendar(seconds_mon.epoch_seconds);
            pending_dates.push_back(exp_date);
         end
      end
      pending_total = pending_dates.size();
   end

endmodule

// File: tb/tb_epoch_seconds_to_calendar.sv
module tb_epoch_seconds_to_calendar;
   import es2cal_pkg::*;

   localparam int SECONDS_WIDTH = SECONDS_WIDTH_DEFAULT;
   localparam int RANDOM_WORDS  = 1150;
   localparam int MAX_GAP       = 10;
   localparam int DRAIN_CYCLES  = 100;
   localparam longint MAX_STAMP = (longint'(1) << SECONDS_WIDTH) - 1;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;

   es2cal_req_if #(.SECONDS_WIDTH(SECONDS_WIDTH)) seconds_chan ();
   es2cal_rsp_if calendar_chan ();

   epoch_seconds_to_calendar #(.SECONDS_WIDTH(SECONDS_WIDTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (seconds_chan),
      .rsp_chan (calendar_chan)
   );

   calendar_check #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_calendar_check (
      .clock        (clock),
      .reset        (reset),
      .seconds_mon  (seconds_chan),
      .calendar_mon (calendar_chan),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // watchdog
   initial begin
      #1000000;
      $display("status: fail");
      $finish;
   end

   // seconds count of a utc date and time
   function automatic longint stamp_at(int year, int month, int day, int hh, int mm, int ss);
      longint y, era, yoe, doy, doe;
      y = (month <= 2) ? year - 1 : year;
      era = y / 400;
      yoe = y - era * 400;
      doy = (153 * ((month > 2) ? month - 3 : month + 9) + 2) / 5 + day - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return (era * DAYS_400Y + doe - EPOCH_SHIFT) * SECONDS_PER_DAY
             + hh * 3600 + mm * 60 + ss;
   endfunction

   // mostly words close to month, year and century edges, the rest raw bits or values below 2^31
   function automatic logic [SECONDS_WIDTH-1:0] random_stamp();
      logic [63:0] raw;
      longint      s;
      int          year, month;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: return raw[SECONDS_WIDTH-1:0];
         3: return SECONDS_WIDTH'($urandom_range(0, 32'h7fffffff));
         default: begin
            case ($urandom_range(0, 3))
               0: year = 100 * $urandom_range(20, 41);
               1: year = $urandom_range(1970, 4146);
               default: year = $urandom_range(1970, 2110);
            endcase
            month = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
            s = stamp_at(year, month, 1, 0, 0, 0)
                + longint'($urandom_range(0, 4 * SECONDS_PER_DAY)) - 2 * SECONDS_PER_DAY;
            if (s < 0) begin
               s = -s;
            end
            if (s > MAX_STAMP) begin
               s = MAX_STAMP;
            end
            return s[SECONDS_WIDTH-1:0];
         end
      endcase
   endfunction

   // offer one word after a random gap unless no_gap is set, hold it until taken
   task automatic send_word(longint stamp, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         seconds_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      seconds_chan.valid <= 1'b1;
      seconds_chan.epoch_seconds <= stamp[SECONDS_WIDTH-1:0];
      do @(posedge clock); while (!(seconds_chan.valid && seconds_chan.ready));
   endtask

   // stop sending until every predicted word has come back
   task automatic drain_results();
      seconds_chan.valid <= 1'b0;
      @(negedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   // result side: random stalls with stretches of steady ready
   initial begin
      int gap;
      int taken;
      calendar_chan.ready = 1'b0;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ((taken % 200) < 40) ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            calendar_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         calendar_chan.ready <= 1'b1;
         do @(posedge clock); while (!(calendar_chan.valid && calendar_chan.ready));
         taken++;
      end
   end

   // stimulus and verdict
   initial begin
      reset = 1'b1;
      seconds_chan.valid = 1'b0;
      seconds_chan.epoch_seconds = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // field edges of the time of day
      send_word(0, 1'b0);
      send_word(1, 1'b0);
      send_word(59, 1'b0);
      send_word(60, 1'b0);
      send_word(3599, 1'b0);
      send_word(3600, 1'b0);
      send_word(SECONDS_PER_DAY - 1, 1'b0);
      send_word(SECONDS_PER_DAY, 1'b0);
      // raw bit patterns and the top of the input range
      send_word(MAX_STAMP, 1'b0);
      send_word(36'hAAAAAAAAA, 1'b0);
      send_word(36'h555555555, 1'b0);
      send_word(32'hFFFFFFFF, 1'b0);
      send_word(longint'(1) << 32, 1'b0);
      // leap day rules: every fourth year, not centuries, but every fourth century
      send_word(stamp_at(1972, 12, 31, 23, 59, 59), 1'b0);
      send_word(stamp_at(2023, 12, 31, 23, 59, 59), 1'b0);
      send_word(stamp_at(2000, 2, 29, 23, 59, 59), 1'b0);
      send_word(stamp_at(2000, 12, 31, 23, 59, 59), 1'b0);
      send_word(stamp_at(2100, 2, 28, 23, 59, 59), 1'b0);
      send_word(stamp_at(2100, 3, 1, 0, 0, 0), 1'b0);
      send_word(stamp_at(2400, 2, 29, 12, 0, 0), 1'b0);
      send_word(stamp_at(2038, 1, 19, 3, 14, 8), 1'b0);
      drain_results();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         send_word(random_stamp(), (n % 170) < 30);
         if (n == RANDOM_WORDS / 2) begin
            drain_results();
         end
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
design/es2cal_pkg.sv
design/es2cal_if.sv
design/es2cal_cdiv.sv
design/es2cal_dly.sv
design/es2cal_tod.sv
design/es2cal_civil.sv
design/epoch_seconds_to_calendar.sv
tb/calendar_check.sv
tb/tb_epoch_seconds_to_calendar.sv
